// ----- sv/grid_point_dedup_lookup_unit_assert.svh -----
// Assertion macros for the grid point lookup unit
`ifndef GRID_POINT_DEDUP_LOOKUP_UNIT_ASSERT_SVH
`define GRID_POINT_DEDUP_LOOKUP_UNIT_ASSERT_SVH

// checked only out of reset
`define GPDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GPDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/gpdl_pkg.sv -----
package gpdl_pkg;

  localparam int IDX_W     = 12;
  localparam int DIV_STEPS = 33;

  typedef logic signed [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [19:0]        new_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] node_id;
  } out_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [30:0]        cell_x;
    logic [30:0]        cell_y;
    logic [30:0]        cell_z;
    logic [63:0]        radius_sq;
  } cfg_t;

  typedef struct packed {
    in_t  item;
    idx_t ix;
    idx_t iy;
    idx_t iz;
  } job_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [19:0]        id;
  } slot_t;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_CELL_X    = 3'd3;
  localparam logic [2:0] REG_CELL_Y    = 3'd4;
  localparam logic [2:0] REG_CELL_Z    = 3'd5;
  localparam logic [2:0] REG_RADIUS_SQ = 3'd6;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_CELL, B_CNT, B_SLOT, B_DRAIN, B_INS_RD, B_INS_CHK, B_OUT
  } back_state_t;

  // neighbor order per axis: 0, -1, +1
  function automatic idx_t nbr_off(logic [1:0] n);
    idx_t r;
    case (n)
      2'd1:    r = idx_t'(-1);
      2'd2:    r = idx_t'(1);
      default: r = idx_t'(0);
    endcase
    return r;
  endfunction

endpackage

// ----- sv/grid_point_dedup_lookup_unit.sv -----
// Channel  Dir  Handshake              Payload
// in_      in   in_valid / in_ready    in_data   (in_t: cmd, x, y, z, new_id)
// out_     out  out_valid / out_ready  out_data  (out_t: status, node_id)
// cfg_     in   cfg_we                 cfg_idx, cfg_wdata
// Front: three 33-step restoring dividers run side by side; it takes a new item
// only after pushing the last. Back: find-or-insert visits each in-grid neighbor
// cell before inserting, reading its stored slots and draining the distance pipe
// when the cell is not empty.
// After reset the bucket counts are cleared, one cell a cycle, with in_ready low
// until all GRID_X*GRID_Y*GRID_Z cells are done; cfg writes are taken throughout.
// A two-entry queue lets the front divide ahead while the back searches.
module grid_point_dedup_lookup_unit import gpdl_pkg::*; #(
  parameter int GRID_X       = 16,
  parameter int GRID_Y       = 16,
  parameter int GRID_Z       = 16,
  parameter int BUCKET_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  logic push_valid, push_ready, head_valid, job_pop, clearing;
  logic res_valid, res_ready;
  job_t push_data, head_data;
  out_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_ORIGIN_X:  cfg_nxt.origin_x  = cfg_wdata[31:0];
        REG_ORIGIN_Y:  cfg_nxt.origin_y  = cfg_wdata[31:0];
        REG_ORIGIN_Z:  cfg_nxt.origin_z  = cfg_wdata[31:0];
        REG_CELL_X:    cfg_nxt.cell_x    = cfg_wdata[30:0];
        REG_CELL_Y:    cfg_nxt.cell_y    = cfg_wdata[30:0];
        REG_CELL_Z:    cfg_nxt.cell_z    = cfg_wdata[30:0];
        REG_RADIUS_SQ: cfg_nxt.radius_sq = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{origin_x: 32'sd0, origin_y: 32'sd0, origin_z: 32'sd0,
                       cell_x: 31'd65536, cell_y: 31'd65536, cell_z: 31'd65536,
                       radius_sq: 64'd1};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gpdl_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .hold       (clearing),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gpdl_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (job_pop)
  );

  gpdl_back #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .BUCKET_SLOTS(BUCKET_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .radius_sq (cfg_r.radius_sq),
    .job_valid (head_valid),
    .job       (head_data),
    .job_pop   (job_pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

endmodule

// ----- sv/gpdl_front.sv -----
module gpdl_front import gpdl_pkg::*; #(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic hold,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic push_valid,
  input  logic push_ready,
  output job_t push_data
);

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  front_state_t      state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  in_t               item_r;
  logic [32:0]       dd_r [3];
  logic [31:0]       rem_r [3];
  logic              neg_r [3];

  logic signed [31:0] crd [3];
  logic signed [31:0] org [3];
  logic [30:0]        cel [3];
  logic [32:0]        off [3];
  logic [32:0]        mag [3];
  logic [32:0]        dd_nxt [3];
  logic [31:0]        rem_nxt [3];
  logic               accept;

  function automatic idx_t to_idx(logic [32:0] q, logic rz, logic neg, int g_n);
    idx_t r;
    if (!neg) begin
      r = (q > 33'(g_n + 1)) ? idx_t'(g_n + 1) : q[IDX_W-1:0];
    end else begin
      r = (q != 33'd0 || rz) ? ((q >= 33'd2 || (q == 33'd1 && rz)) ? idx_t'(-2) : idx_t'(-1))
                             : idx_t'(0);
    end
    return r;
  endfunction

  assign accept = in_valid && in_ready;

  always_comb begin
    logic [32:0] t;
    logic [32:0] dv;
    crd[0] = in_data.x;
    crd[1] = in_data.y;
    crd[2] = in_data.z;
    org[0] = cfg.origin_x;
    org[1] = cfg.origin_y;
    org[2] = cfg.origin_z;
    cel[0] = (cfg.cell_x == 31'd0) ? 31'd1 : cfg.cell_x;
    cel[1] = (cfg.cell_y == 31'd0) ? 31'd1 : cfg.cell_y;
    cel[2] = (cfg.cell_z == 31'd0) ? 31'd1 : cfg.cell_z;
    for (int g = 0; g < 3; g++) begin
      off[g] = {crd[g][31], crd[g]} - {org[g][31], org[g]};
      mag[g] = off[g][32] ? (33'd0 - off[g]) : off[g];
      t  = {rem_r[g], dd_r[g][32]};
      dv = {2'b00, cel[g]};
      if (t >= dv) begin
        rem_nxt[g] = 32'(t - dv);
        dd_nxt[g]  = {dd_r[g][31:0], 1'b1};
      end else begin
        rem_nxt[g] = t[31:0];
        dd_nxt[g]  = {dd_r[g][31:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_DIV;
          step_nxt  = '0;
        end
      end
      F_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == F_IDLE) && !hold;
    push_valid = (state_r == F_PUSH);
    push_data.item = item_r;
    push_data.ix   = to_idx(dd_r[0], rem_r[0] != 32'd0, neg_r[0], GRID_X);
    push_data.iy   = to_idx(dd_r[1], rem_r[1] != 32'd0, neg_r[1], GRID_Y);
    push_data.iz   = to_idx(dd_r[2], rem_r[2] != 32'd0, neg_r[2], GRID_Z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      for (int g = 0; g < 3; g++) begin
        dd_r[g]  <= mag[g];
        rem_r[g] <= '0;
        neg_r[g] <= off[g][32];
      end
    end else if (state_r == F_DIV) begin
      for (int g = 0; g < 3; g++) begin
        dd_r[g]  <= dd_nxt[g];
        rem_r[g] <= rem_nxt[g];
      end
    end
  end

endmodule

// ----- sv/gpdl_fifo.sv -----
module gpdl_fifo import gpdl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic head_valid,
  output job_t head_data,
  input  logic pop
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !do_push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- sv/gpdl_back.sv -----
module gpdl_back import gpdl_pkg::*; #(
  parameter int GRID_X       = 16,
  parameter int GRID_Y       = 16,
  parameter int GRID_Z       = 16,
  parameter int BUCKET_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] radius_sq,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  output logic        clearing,
  output logic        res_valid,
  output out_t        res,
  input  logic        res_ready
);

  localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int NSLOTS = NCELLS * BUCKET_SLOTS;
  localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int CNTW   = $clog2(BUCKET_SLOTS + 1);

  back_state_t     state_r, state_nxt;
  logic [CW-1:0]   clr_r, clr_nxt;
  logic [1:0]      na_r, na_nxt, nb_r, nb_nxt, nc_r, nc_nxt;
  logic [CW-1:0]   cell_r, cell_nxt;
  logic [CNTW-1:0] s_r, s_nxt;
  out_t            res_r, res_nxt;
  logic            p1_v_r, p2_v_r;

  logic [CNTW-1:0] cnt_mem [NCELLS];
  logic [CNTW-1:0] cnt_rd_r;
  slot_t           slot_mem [NSLOTS];
  slot_t           slot_rd_r;

  logic [63:0] sqx_r, sqy_r, sqz_r;
  logic [19:0] id_p2_r;

  logic            cnt_we, cnt_re, slot_we, slot_re;
  logic [CW-1:0]   cnt_waddr, cnt_raddr;
  logic [CNTW-1:0] cnt_wdata;
  logic [AW-1:0]   slot_waddr, slot_raddr;
  slot_t           slot_wdata;

  idx_t          nx, ny, nz;
  logic          nb_ok, in_grid, last_nb, adv, match, full;
  logic [CW-1:0] nb_cell, own_cell;
  logic [64:0]   s1, s2;
  logic [63:0]   s1_sat, dsum;

  function automatic logic [63:0] sq_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic [32:0] d;
    logic [32:0] m;
    logic [65:0] p;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? (33'd0 - d) : d;
    p = {33'd0, m} * {33'd0, m};
    return p[63:0];
  endfunction

  always_comb begin
    nx = job.ix + nbr_off(na_r);
    ny = job.iy + nbr_off(nb_r);
    nz = job.iz + nbr_off(nc_r);
    nb_ok = (nx >= 0) && (nx < GRID_X) && (ny >= 0) && (ny < GRID_Y) &&
            (nz >= 0) && (nz < GRID_Z);
    nb_cell = CW'(int'(nx) + int'(ny) * GRID_X + int'(nz) * GRID_X * GRID_Y);
    in_grid = (job.ix >= 0) && (job.ix < GRID_X) && (job.iy >= 0) &&
              (job.iy < GRID_Y) && (job.iz >= 0) && (job.iz < GRID_Z);
    own_cell = CW'(int'(job.ix) + int'(job.iy) * GRID_X + int'(job.iz) * GRID_X * GRID_Y);
    last_nb = (na_r == 2'd2) && (nb_r == 2'd2) && (nc_r == 2'd2);
    full = (cnt_rd_r >= CNTW'(BUCKET_SLOTS));
    s1 = {1'b0, sqx_r} + {1'b0, sqy_r};
    s1_sat = s1[64] ? '1 : s1[63:0];
    s2 = {1'b0, s1_sat} + {1'b0, sqz_r};
    dsum = s2[64] ? '1 : s2[63:0];
    match = p2_v_r && (dsum < radius_sq) &&
            ((state_r == B_SLOT) || (state_r == B_DRAIN));
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    nc_nxt    = nc_r;
    cell_nxt  = cell_r;
    s_nxt     = s_r;
    res_nxt   = res_r;
    adv       = 1'b0;
    case (state_r)
      B_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(NCELLS - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (job_valid) begin
          na_nxt    = '0;
          nb_nxt    = '0;
          nc_nxt    = '0;
          state_nxt = job.item.cmd ? B_CELL : B_INS_RD;
        end
      end
      B_CELL: begin
        if (nb_ok) begin
          cell_nxt  = nb_cell;
          state_nxt = B_CNT;
        end else begin
          adv = 1'b1;
        end
      end
      B_CNT: begin
        s_nxt = '0;
        if (cnt_rd_r == '0) adv = 1'b1;
        else state_nxt = B_SLOT;
      end
      B_SLOT: begin
        if (match) begin
          res_nxt   = '{status: ST_MATCH, node_id: id_p2_r};
          state_nxt = B_OUT;
        end else begin
          s_nxt = s_r + 1'b1;
          if (s_r + 1'b1 == cnt_rd_r) state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (match) begin
          res_nxt   = '{status: ST_MATCH, node_id: id_p2_r};
          state_nxt = B_OUT;
        end else if (!p1_v_r && !p2_v_r) begin
          adv = 1'b1;
        end
      end
      B_INS_RD: begin
        if (!in_grid) begin
          res_nxt   = '{status: ST_OUTSIDE, node_id: job.item.new_id};
          state_nxt = B_OUT;
        end else begin
          state_nxt = B_INS_CHK;
        end
      end
      B_INS_CHK: begin
        res_nxt   = '{status: (full ? ST_FULL : ST_INSERTED), node_id: job.item.new_id};
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (res_ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
    if (adv) begin
      if (last_nb) begin
        state_nxt = B_INS_RD;
      end else begin
        state_nxt = B_CELL;
        if (na_r != 2'd2) begin
          na_nxt = na_r + 2'd1;
        end else begin
          na_nxt = '0;
          if (nb_r != 2'd2) begin
            nb_nxt = nb_r + 2'd1;
          end else begin
            nb_nxt = '0;
            nc_nxt = nc_r + 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    clearing   = (state_r == B_CLEAR);
    cnt_we     = 1'b0;
    cnt_waddr  = clr_r;
    cnt_wdata  = '0;
    cnt_re     = 1'b0;
    cnt_raddr  = nb_cell;
    slot_we    = 1'b0;
    slot_waddr = AW'(int'(own_cell) * BUCKET_SLOTS + int'(cnt_rd_r));
    slot_wdata = '{x: job.item.x, y: job.item.y, z: job.item.z, id: job.item.new_id};
    slot_re    = 1'b0;
    slot_raddr = AW'(int'(cell_r) * BUCKET_SLOTS + int'(s_r));
    res_valid  = (state_r == B_OUT);
    job_pop    = (state_r == B_OUT) && res_ready;
    case (state_r)
      B_CLEAR: cnt_we = 1'b1;
      B_CELL:  cnt_re = nb_ok;
      B_SLOT:  slot_re = !match;
      B_INS_RD: begin
        cnt_re    = in_grid;
        cnt_raddr = own_cell;
      end
      B_INS_CHK: begin
        cnt_we    = !full;
        cnt_waddr = own_cell;
        cnt_wdata = cnt_rd_r + 1'b1;
        slot_we   = !full;
      end
      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      na_r    <= '0;
      nb_r    <= '0;
      nc_r    <= '0;
      s_r     <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      na_r    <= na_nxt;
      nb_r    <= nb_nxt;
      nc_r    <= nc_nxt;
      s_r     <= s_nxt;
      p1_v_r  <= slot_re;
      p2_v_r  <= p1_v_r && !match;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    sqx_r   <= sq_diff(slot_rd_r.x, job.item.x);
    sqy_r   <= sq_diff(slot_rd_r.y, job.item.y);
    sqz_r   <= sq_diff(slot_rd_r.z, job.item.z);
    id_p2_r <= slot_rd_r.id;
  end

endmodule

// ----- sv/gpdl_checker.sv -----
`include "grid_point_dedup_lookup_unit_assert.svh"

module gpdl_checker import gpdl_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic [3:0] pend_r, pend_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) pend_nxt = pend_r + 4'd1;
    else if (out_xfer && !in_xfer) pend_nxt = pend_r - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_nxt;
  end

  // every result transfer answers an earlier accepted item
  `GPDL_ASSERT(a_no_extra_result, out_xfer |-> pend_r != 4'd0, "result without item")
  // front, queue and output register hold at most four items
  `GPDL_ASSERT(a_pending_bound, pend_r <= 4'd4, "too many items in flight")
  `GPDL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
  `GPDL_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_ready, "active after reset")

endmodule

bind grid_point_dedup_lookup_unit gpdl_checker u_gpdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
